// File: design/bounded_deque_with_insert_top_assert.svh
// assertion macros used by the deque top design file
`ifndef BOUNDED_DEQUE_WITH_INSERT_TOP_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_INSERT_TOP_ASSERT_SVH

// same-cycle implication
`define BDQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// File: design/bdeque_pkg.sv
// constants and codes for the bounded deque with insert
package bdeque_pkg;

   localparam int DEF_CAPACITY = 16;

   localparam int MODE_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_READ_OUT   = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

endpackage

// File: design/bounded_deque_with_insert_top.sv
// bounded deque with positional insert, one memory port pair under a small sequencer
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_mode, req_value, req_position
//   rsp      out  rsp_valid / rsp_stall  rsp_item_value, rsp_status, rsp_count,
//                                        rsp_is_empty, rsp_last
//
// push back, pop back, clear, errors and unused mode: decided in idle, result beat from the done state
// push front and insert: one read and one write per entry moved, then the new value is written
// pop front: one read and one write per entry behind the head; read out: one read per entry beat
// req_stall is high while the sequencer is busy; a result beat waits in the output register
// synchronous reset empties the list; memory contents are not cleared

`include "bounded_deque_with_insert_top_assert.svh"

module bounded_deque_with_insert_top
   import bdeque_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_item_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_last
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SU_READ  = 3'd1;
   localparam logic [2:0] S_SU_WRITE = 3'd2;
   localparam logic [2:0] S_SD_READ  = 3'd3;
   localparam logic [2:0] S_SD_WRITE = 3'd4;
   localparam logic [2:0] S_RD_ISSUE = 3'd5;
   localparam logic [2:0] S_RD_WAIT  = 3'd6;
   localparam logic [2:0] S_DONE     = 3'd7;

   logic signed [VALUE_W-1:0] mem_ff [CAPACITY];
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic [2:0]                state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [STATUS_W-1:0]       status_ff, status_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_item_ff, rsp_item_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   logic                      accept;
   logic                      out_free;
   logic                      is_full;
   logic                      is_empty;
   logic [CMPW-1:0]           pos_ext;
   logic [CMPW-1:0]           cnt_ext;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign pos_ext  = CMPW'(req_position);
   assign cnt_ext  = CMPW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = rd_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_OK;
               state_in  = S_DONE;
               case (req_mode)
                  MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else if (req_mode == MODE_INSERT &&
                                  (pos_ext == '0 || pos_ext > cnt_ext)) begin
                        status_in = ST_BADPOS;
                     end else if (req_mode == MODE_PUSH_BACK) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        // make room by moving the tail back one slot at a time
                        idx_in   = (req_mode == MODE_INSERT) ? pos_ext[AW-1:0] : '0;
                        ptr_in   = count_ff[AW-1:0];
                        val_in   = req_value;
                        state_in = S_SU_READ;
                     end
                  end
                  MODE_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_SD_READ;
                     end
                  end
                  MODE_POP_BACK: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  MODE_READ_OUT: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        ptr_in   = '0;
                        state_in = S_RD_ISSUE;
                     end
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SU_READ: begin
            if (ptr_ff > idx_ff) begin
               rd_en    = 1'b1;
               rd_addr  = ptr_ff - 1'b1;
               state_in = S_SU_WRITE;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_data  = val_ff;
               count_in = count_ff + 1'b1;
               state_in = S_DONE;
            end
         end
         S_SU_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            ptr_in   = ptr_ff - 1'b1;
            state_in = S_SU_READ;
         end
         S_SD_READ: begin
            if ((CW'(ptr_ff) + 1'b1) < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = ptr_ff + 1'b1;
               state_in = S_SD_WRITE;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end
         end
         S_SD_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = ptr_ff;
            ptr_in   = ptr_ff + 1'b1;
            state_in = S_SD_READ;
         end
         S_RD_ISSUE: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff;
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = rd_data_ff;
               rsp_status_in = ST_OK;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_empty_in  = 1'b0;
               rsp_last_in   = (CW'(ptr_ff) + 1'b1) == count_ff;
               if ((CW'(ptr_ff) + 1'b1) == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_RD_ISSUE;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '0;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_empty_in  = is_empty;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      idx_ff        <= idx_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_value = rsp_item_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_last       = rsp_last_ff;

   `BDQ_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `BDQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE)
   `BDQ_ASSERT_NEXT(a_readout_count, clock, reset, state_ff == S_RD_WAIT, $stable(count_ff))
   `BDQ_ASSERT_IMP(a_shift_room, clock, reset, state_ff == S_SU_WRITE, CW'(ptr_ff) <= count_ff && count_ff < CW'(CAPACITY))

endmodule

// File: sim/testbench.sv
// self-checking testbench for the bounded deque with insert: directed table, then random beats
`timescale 1ns / 1ps

module testbench;
   import bdeque_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 48;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [VALUE_W-1:0] item_value;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
      logic                      is_empty;
      logic                      last;
   } rsp_beat_type;

   typedef struct {
      logic [MODE_W-1:0]         mode;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
      int                        reps;
      bit                        typed;
      logic [STATUS_W-1:0]       exp_status;
      logic [COUNT_W-1:0]        exp_count;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode;
   logic signed [VALUE_W-1:0] req_value;
   logic [POS_W-1:0]          req_position;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [VALUE_W-1:0] rsp_item_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [COUNT_W-1:0]        rsp_count;
   logic                      rsp_is_empty;
   logic                      rsp_last;

   // hand-typed expectation riding along with the request beat
   logic                      beat_typed;
   logic [STATUS_W-1:0]       beat_exp_status;
   logic [COUNT_W-1:0]        beat_exp_count;

   logic signed [VALUE_W-1:0] model_entries [CAP];
   int                        model_count;
   rsp_beat_type              expected_beats [$];
   stim_row_type              directed_rows [$];
   int                        error_count;
   int                        tx_idle_pct;
   int                        rx_idle_pct;

   bounded_deque_with_insert_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_item_value (rsp_item_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic rsp_beat_type make_beat(input logic signed [VALUE_W-1:0] v,
                                              input logic [STATUS_W-1:0] st, input logic fin);
      rsp_beat_type b;
      b.item_value = v;
      b.status     = st;
      b.count      = COUNT_W'(model_count);
      b.is_empty   = (model_count == 0);
      b.last       = fin;
      return b;
   endfunction

   // applies one request to the shadow deque and queues the result beats it causes
   task automatic deque_apply(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
                              input logic [POS_W-1:0] p);
      logic [STATUS_W-1:0] st;
      int                  slot;
      bit                  do_place;
      int                  i;
      st = ST_OK;
      slot = 0;
      do_place = 1'b0;
      case (m)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (model_count >= CAP) st = ST_FULL;
            else begin
               do_place = 1'b1;
               slot = (m == MODE_PUSH_FRONT) ? 0 : model_count;
            end
         end
         MODE_POP_FRONT: begin
            if (model_count == 0) st = ST_EMPTY;
            else begin
               for (i = 0; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
               model_count--;
            end
         end
         MODE_POP_BACK: begin
            if (model_count == 0) st = ST_EMPTY;
            else model_count--;
         end
         MODE_INSERT: begin
            if (model_count >= CAP) st = ST_FULL;
            else if (p == 0 || int'(p) > model_count) st = ST_BADPOS;
            else begin
               do_place = 1'b1;
               slot = int'(p);
            end
         end
         MODE_CLEAR: model_count = 0;
         MODE_READ_OUT: begin
            if (model_count != 0) begin
               for (i = 0; i < model_count; i++)
                  expected_beats.insert(expected_beats.size(),
                                        make_beat(model_entries[i], ST_OK,
                                                  i + 1 == model_count));
               return;
            end
            st = ST_EMPTY;
         end
         default: ;
      endcase
      if (do_place) begin
         for (i = model_count; i > slot; i--) model_entries[i] = model_entries[i - 1];
         model_entries[slot] = v;
         model_count++;
      end
      expected_beats.insert(expected_beats.size(), make_beat('0, st, 1'b1));
   endtask

   // request side: predict on accept; result side: compare with the oldest expectation
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            deque_apply(req_mode, req_value, req_position);
            if (beat_typed) begin
               want = expected_beats[expected_beats.size() - 1];
               want.item_value = '0;
               want.status     = beat_exp_status;
               want.count      = beat_exp_count;
               want.is_empty   = (beat_exp_count == 0);
               want.last       = 1'b1;
               expected_beats[expected_beats.size() - 1] = want;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.item_value = rsp_item_value;
            got.status     = rsp_status;
            got.count      = rsp_count;
            got.is_empty   = rsp_is_empty;
            got.last       = rsp_last;
            if (expected_beats.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("unexpected result beat: value %0d status %0d count %0d",
                           got.item_value, got.status, got.count);
            end else begin
               want = expected_beats[0];
               expected_beats.delete(0);
               if (got.item_value !== want.item_value || got.status !== want.status ||
                   got.count !== want.count || got.is_empty !== want.is_empty ||
                   got.last !== want.last) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("mismatch: exp %0d/%0d/%0d/%0b/%0b got %0d/%0d/%0d/%0b/%0b",
                              want.item_value, want.status, want.count, want.is_empty,
                              want.last, got.item_value, got.status, got.count,
                              got.is_empty, got.last);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
   end

   task automatic add_row(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
                          input logic [POS_W-1:0] p, input int reps, input bit typed,
                          input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] cnt);
      stim_row_type r;
      r.mode = m;
      r.value = v;
      r.position = p;
      r.reps = reps;
      r.typed = typed;
      r.exp_status = st;
      r.exp_count = cnt;
      directed_rows.insert(directed_rows.size(), r);
   endtask

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_request(input logic [MODE_W-1:0] m, input logic signed [VALUE_W-1:0] v,
                               input logic [POS_W-1:0] p, input bit typed,
                               input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] cnt);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= m;
      req_value       <= v;
      req_position    <= p;
      beat_typed      <= typed;
      beat_exp_status <= st;
      beat_exp_count  <= cnt;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   initial begin
      logic [MODE_W-1:0]         m;
      logic signed [VALUE_W-1:0] v;
      logic [POS_W-1:0]          p;
      int                        r;
      int                        grow_pct;
      int                        phase;
      int                        k;
      int                        j;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_PUSH_BACK;
      req_value = '0;
      req_position = '0;
      beat_typed = 1'b0;
      beat_exp_status = ST_OK;
      beat_exp_count = '0;
      model_count = 0;
      error_count = 0;
      tx_idle_pct = 14;
      rx_idle_pct = 60;

      // empty-list errors, then one-entry pushes and pops, then inserts, fill to full, full errors and clear
      add_row(MODE_POP_FRONT,  0, 0, 1, 1, ST_EMPTY,  0);
      add_row(MODE_POP_BACK,   0, 0, 1, 1, ST_EMPTY,  0);
      add_row(MODE_READ_OUT,   0, 0, 1, 1, ST_EMPTY,  0);
      add_row(MODE_INSERT,     5, 0, 1, 1, ST_BADPOS, 0);
      add_row(MODE_INSERT,     5, 1, 1, 1, ST_BADPOS, 0);
      add_row(MODE_CLEAR,      0, 0, 1, 1, ST_OK,     0);
      add_row(MODE_UNUSED,    -1, 31, 1, 1, ST_OK,    0);
      add_row(MODE_PUSH_FRONT, 32'sh7fffffff, 0, 1, 1, ST_OK, 1);
      add_row(MODE_POP_FRONT,  0, 0, 1, 1, ST_OK,     0);
      add_row(MODE_PUSH_BACK,  32'sh80000000, 0, 1, 1, ST_OK, 1);
      add_row(MODE_POP_BACK,   0, 0, 1, 1, ST_OK,     0);
      add_row(MODE_PUSH_BACK,  32'sh80000000, 0, 1, 0, ST_OK, 0);
      add_row(MODE_PUSH_FRONT, 32'sh7fffffff, 0, 1, 0, ST_OK, 0);
      add_row(MODE_INSERT,    -1, 2, 1, 0, ST_OK,     0);
      add_row(MODE_INSERT,     0, 1, 1, 0, ST_OK,     0);
      add_row(MODE_INSERT,     9, 5, 1, 1, ST_BADPOS, 4);
      add_row(MODE_INSERT,     9, 16, 1, 1, ST_BADPOS, 4);
      add_row(MODE_READ_OUT,   0, 0, 1, 0, ST_OK,     0);
      add_row(MODE_POP_FRONT,  0, 0, 1, 0, ST_OK,     0);
      add_row(MODE_POP_BACK,   0, 0, 1, 0, ST_OK,     0);
      add_row(MODE_PUSH_BACK,  32'sh1000, 0, CAP - 2, 0, ST_OK, 0);
      add_row(MODE_PUSH_FRONT, 1, 0, 1, 1, ST_FULL,   CAP);
      add_row(MODE_PUSH_BACK,  1, 0, 1, 1, ST_FULL,   CAP);
      add_row(MODE_INSERT,     1, 16, 1, 1, ST_FULL,  CAP);
      add_row(MODE_INSERT,     1, 0, 1, 1, ST_FULL,   CAP);
      add_row(MODE_READ_OUT,   0, 0, 1, 0, ST_OK,     0);
      add_row(MODE_POP_FRONT,  0, 0, 1, 0, ST_OK,     0);
      add_row(MODE_INSERT,     32'sh55555555, 15, 1, 0, ST_OK, 0);
      add_row(MODE_READ_OUT,   0, 0, 1, 0, ST_OK,     0);
      add_row(MODE_CLEAR,      0, 0, 1, 1, ST_OK,     0);
      add_row(MODE_READ_OUT,   0, 0, 1, 1, ST_EMPTY,  0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         for (j = 0; j < directed_rows[i].reps; j++)
            send_request(directed_rows[i].mode, directed_rows[i].value + j,
                         directed_rows[i].position, directed_rows[i].typed,
                         directed_rows[i].exp_status, directed_rows[i].exp_count);

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 14; rx_idle_pct = 60; end
            1: begin tx_idle_pct = 60; rx_idle_pct = 14; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (k = 0; k < RANDOM_ITEMS / 3 + 1; k++) begin
            // swing between filling and draining so both full and empty get hit
            grow_pct = ((k / 30) % 2 == 0) ? 80 : 20;
            v = $urandom();
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0: v = 32'sh7fffffff;
                  1: v = 32'sh80000000;
                  2: v = 0;
                  default: v = -1;
               endcase
            end
            p = POS_W'($urandom_range(0, 16));
            r = $urandom_range(0, 99);
            if (r < 3) m = MODE_CLEAR;
            else if (r < 10) m = MODE_READ_OUT;
            else if (r < 12) m = MODE_UNUSED;
            else if (r < 18) begin
               m = MODE_INSERT;
               if (model_count < CAP)
                  p = ($urandom_range(0, 1) == 0) ? POS_W'(0) :
                      POS_W'($urandom_range(model_count + 1, 16));
            end else if ($urandom_range(0, 99) < grow_pct) begin
               case ($urandom_range(0, 2))
                  0: m = MODE_PUSH_FRONT;
                  1: m = MODE_PUSH_BACK;
                  default: begin
                     m = MODE_INSERT;
                     p = (model_count == 0) ? POS_W'(0) :
                         POS_W'($urandom_range(1, model_count));
                  end
               endcase
            end else
               m = ($urandom_range(0, 1) == 0) ? MODE_POP_FRONT : MODE_POP_BACK;
            send_request(m, v, p, 1'b0, ST_OK, '0);
         end
      end
      req_valid <= 1'b0;

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_beats.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
